@@ rtl/cigar_affine_score_local_trim_macros.svh @@
// Assertion helpers, clocked on clk_i and held off during reset.
`ifndef CIGAR_AFFINE_SCORE_LOCAL_TRIM_MACROS_SVH
`define CIGAR_AFFINE_SCORE_LOCAL_TRIM_MACROS_SVH

// Check an expression at every edge.
`define CASLT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a consequent in the cycle after an antecedent.
`define CASLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/caslt_pkg.sv @@
package caslt_pkg;

  localparam int POSITION_BITS_DEFAULT = 24;
  localparam int RUN_BITS_DEFAULT      = 16;

  localparam int COEF_BITS  = 6;
  localparam int TOTAL_BITS = 31;
  localparam int LOCAL_BITS = 30;

  localparam logic signed [TOTAL_BITS-1:0] TOTAL_MAX = 31'sh3FFF_FFFF;
  localparam logic signed [TOTAL_BITS-1:0] TOTAL_MIN = -31'sh4000_0000;
  localparam logic [LOCAL_BITS-1:0]        LOCAL_MAX = '1;

  localparam logic [COEF_BITS-1:0] MATCH_RESET      = 6'd1;
  localparam logic [COEF_BITS-1:0] MISMATCH_RESET   = 6'd4;
  localparam logic [COEF_BITS-1:0] GAP_OPEN_RESET   = 6'd6;
  localparam logic [COEF_BITS-1:0] GAP_EXTEND_RESET = 6'd1;

  typedef enum logic [1:0] {
    CFG_MATCH      = 2'd0,
    CFG_MISMATCH   = 2'd1,
    CFG_GAP_OPEN   = 2'd2,
    CFG_GAP_EXTEND = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    KIND_MATCH    = 3'd0,
    KIND_SEED     = 3'd1,
    KIND_MISMATCH = 3'd2,
    KIND_INSERT   = 3'd3,
    KIND_DELETE   = 3'd4,
    KIND_NONE     = 3'd7
  } kind_e;

endpackage

@@ rtl/cigar_affine_score_local_trim.sv @@
// A beat goes from the input register into the state registers, which also serve as the
// result register; one beat per cycle while the output is not stalled. The score update
// and the position adds sit between the input register and the state registers.
// Reset (async, active low): empty pipeline, all alignment state cleared, previous
// kind set to none, scoring registers back to their defaults.
`include "cigar_affine_score_local_trim_macros.svh"

module cigar_affine_score_local_trim #(
  parameter int POSITION_BITS = caslt_pkg::POSITION_BITS_DEFAULT,
  parameter int RUN_BITS      = caslt_pkg::RUN_BITS_DEFAULT
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [1:0]                              cfg_index_i,
  input  logic [caslt_pkg::COEF_BITS-1:0]         cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    op_i,
  input  logic [2:0]                              run_kind_i,
  input  logic [RUN_BITS-1:0]                     run_size_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [caslt_pkg::TOTAL_BITS-1:0] total_score_o,
  output logic [POSITION_BITS-1:0]                ref_extent_o,
  output logic [POSITION_BITS-1:0]                query_extent_o,
  output logic [POSITION_BITS-1:0]                total_length_o,
  output logic [caslt_pkg::LOCAL_BITS-1:0]        local_score_o,
  output logic [POSITION_BITS-1:0]                local_ref_begin_o,
  output logic [POSITION_BITS-1:0]                local_ref_end_o,
  output logic [POSITION_BITS-1:0]                local_query_begin_o,
  output logic [POSITION_BITS-1:0]                local_query_end_o,
  output logic                                    length_overflow_o
);

  localparam int CoefW = caslt_pkg::COEF_BITS;
  localparam int ProdW = RUN_BITS + CoefW;
  localparam int SumW  = ((RUN_BITS + 8 > caslt_pkg::TOTAL_BITS) ?
                          RUN_BITS + 8 : caslt_pkg::TOTAL_BITS) + 1;
  localparam int PsumW = ((POSITION_BITS > RUN_BITS) ? POSITION_BITS : RUN_BITS) + 1;

  typedef logic [ProdW-1:0]         prod_t;
  typedef logic signed [SumW-1:0]   sum_t;
  typedef logic [PsumW-1:0]         psum_t;
  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [caslt_pkg::LOCAL_BITS-1:0] lscore_t;

  localparam pos_t PosMax = '1;

  // configuration
  logic [CoefW-1:0] match_q, mismatch_q, gap_open_q, gap_extend_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q      <= caslt_pkg::MATCH_RESET;
      mismatch_q   <= caslt_pkg::MISMATCH_RESET;
      gap_open_q   <= caslt_pkg::GAP_OPEN_RESET;
      gap_extend_q <= caslt_pkg::GAP_EXTEND_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (caslt_pkg::cfg_idx_e'(cfg_index_i))
        caslt_pkg::CFG_MATCH:      match_q      <= cfg_data_i;
        caslt_pkg::CFG_MISMATCH:   mismatch_q   <= cfg_data_i;
        caslt_pkg::CFG_GAP_OPEN:   gap_open_q   <= cfg_data_i;
        caslt_pkg::CFG_GAP_EXTEND: gap_extend_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic                in_valid_q;
  logic                in_op_q;
  logic [2:0]          in_kind_q;
  logic [RUN_BITS-1:0] in_size_q;
  logic                out_valid_q;
  logic                advance;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_op_q   <= op_i;
      in_kind_q <= run_kind_i;
      in_size_q <= run_size_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // alignment state, also the result register
  logic [2:0]                              prev_kind_q, prev_kind_d;
  logic signed [caslt_pkg::TOTAL_BITS-1:0] score_q, score_d;
  pos_t                                    ref_q, ref_d, query_q, query_d, len_q, len_d;
  lscore_t                                 running_q, running_d, best_q, best_d;
  pos_t                                    restart_ref_q, restart_ref_d;
  pos_t                                    restart_query_q, restart_query_d;
  pos_t                                    best_rb_q, best_rb_d, best_re_q, best_re_d;
  pos_t                                    best_qb_q, best_qb_d, best_qe_q, best_qe_d;
  logic                                    ovf_q, ovf_d;

  caslt_pkg::kind_e kind;
  logic             kind_ok, gain, adds_ref, adds_query, gap_new, apply;
  logic [CoefW-1:0] coef;
  prod_t            prod;
  sum_t             mag, delta, tot_sum, run_sum;
  psum_t            ref_sum, query_sum, len_sum;
  logic             ref_ovf, query_ovf, len_ovf;
  pos_t             ref_new, query_new, len_new;
  lscore_t          run_new;
  pos_t             rs_ref_new, rs_query_new;
  logic             restart;

  always_comb begin
    kind       = caslt_pkg::kind_e'(in_kind_q);
    kind_ok    = 1'b1;
    gain       = 1'b0;
    adds_ref   = 1'b0;
    adds_query = 1'b0;
    coef       = '0;
    unique case (kind)
      caslt_pkg::KIND_MATCH, caslt_pkg::KIND_SEED: begin
        coef = match_q; gain = 1'b1; adds_ref = 1'b1; adds_query = 1'b1;
      end
      caslt_pkg::KIND_MISMATCH: begin
        coef = mismatch_q; adds_ref = 1'b1; adds_query = 1'b1;
      end
      caslt_pkg::KIND_INSERT: begin
        coef = gap_extend_q; adds_query = 1'b1;
      end
      caslt_pkg::KIND_DELETE: begin
        coef = gap_extend_q; adds_ref = 1'b1;
      end
      default: kind_ok = 1'b0;
    endcase

    gap_new = (kind == caslt_pkg::KIND_INSERT || kind == caslt_pkg::KIND_DELETE) &&
              (prev_kind_q != in_kind_q);
    apply   = (in_op_q == caslt_pkg::OP_APPEND) && kind_ok && (in_size_q != '0);

    prod  = prod_t'(coef) * prod_t'(in_size_q);
    mag   = sum_t'(prod) + (gap_new ? sum_t'(gap_open_q) : sum_t'(0));
    delta = gain ? mag : -mag;

    ref_sum   = psum_t'(ref_q) + psum_t'(in_size_q);
    query_sum = psum_t'(query_q) + psum_t'(in_size_q);
    len_sum   = psum_t'(len_q) + psum_t'(in_size_q);
    ref_ovf   = adds_ref && (ref_sum > psum_t'(PosMax));
    query_ovf = adds_query && (query_sum > psum_t'(PosMax));
    len_ovf   = len_sum > psum_t'(PosMax);
    ref_new   = !adds_ref ? ref_q : (ref_ovf ? PosMax : pos_t'(ref_sum));
    query_new = !adds_query ? query_q : (query_ovf ? PosMax : pos_t'(query_sum));
    len_new   = len_ovf ? PosMax : pos_t'(len_sum);

    tot_sum = sum_t'(score_q) + delta;
    run_sum = sum_t'(running_q) + delta;
    restart = 1'b0;
    priority if (run_sum > sum_t'(caslt_pkg::LOCAL_MAX)) begin
      run_new = caslt_pkg::LOCAL_MAX;
    end else if (run_sum < sum_t'(0)) begin
      run_new = '0;
      restart = 1'b1;
    end else begin
      run_new = lscore_t'(run_sum);
    end
    rs_ref_new   = restart ? ref_new : restart_ref_q;
    rs_query_new = restart ? query_new : restart_query_q;

    prev_kind_d     = prev_kind_q;
    score_d         = score_q;
    ref_d           = ref_q;
    query_d         = query_q;
    len_d           = len_q;
    running_d       = running_q;
    best_d          = best_q;
    restart_ref_d   = restart_ref_q;
    restart_query_d = restart_query_q;
    best_rb_d       = best_rb_q;
    best_re_d       = best_re_q;
    best_qb_d       = best_qb_q;
    best_qe_d       = best_qe_q;
    ovf_d           = ovf_q;

    priority if (in_op_q == caslt_pkg::OP_CLEAR) begin
      prev_kind_d     = caslt_pkg::KIND_NONE;
      score_d         = '0;
      ref_d           = '0;
      query_d         = '0;
      len_d           = '0;
      running_d       = '0;
      best_d          = '0;
      restart_ref_d   = '0;
      restart_query_d = '0;
      best_rb_d       = '0;
      best_re_d       = '0;
      best_qb_d       = '0;
      best_qe_d       = '0;
      ovf_d           = 1'b0;
    end else if (apply) begin
      prev_kind_d = in_kind_q;
      priority if (tot_sum > sum_t'(caslt_pkg::TOTAL_MAX)) begin
        score_d = caslt_pkg::TOTAL_MAX;
      end else if (tot_sum < sum_t'(caslt_pkg::TOTAL_MIN)) begin
        score_d = caslt_pkg::TOTAL_MIN;
      end else begin
        score_d = tot_sum[caslt_pkg::TOTAL_BITS-1:0];
      end
      ref_d           = ref_new;
      query_d         = query_new;
      len_d           = len_new;
      running_d       = run_new;
      restart_ref_d   = rs_ref_new;
      restart_query_d = rs_query_new;
      ovf_d           = ovf_q || ref_ovf || query_ovf || len_ovf;
      if (run_new >= best_q) begin
        best_d    = run_new;
        best_rb_d = rs_ref_new;
        best_qb_d = rs_query_new;
        best_re_d = ref_new;
        best_qe_d = query_new;
      end
    end else begin
      ovf_d = ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_kind_q     <= caslt_pkg::KIND_NONE;
      score_q         <= '0;
      ref_q           <= '0;
      query_q         <= '0;
      len_q           <= '0;
      running_q       <= '0;
      best_q          <= '0;
      restart_ref_q   <= '0;
      restart_query_q <= '0;
      best_rb_q       <= '0;
      best_re_q       <= '0;
      best_qb_q       <= '0;
      best_qe_q       <= '0;
      ovf_q           <= 1'b0;
    end else if (advance) begin
      prev_kind_q     <= prev_kind_d;
      score_q         <= score_d;
      ref_q           <= ref_d;
      query_q         <= query_d;
      len_q           <= len_d;
      running_q       <= running_d;
      best_q          <= best_d;
      restart_ref_q   <= restart_ref_d;
      restart_query_q <= restart_query_d;
      best_rb_q       <= best_rb_d;
      best_re_q       <= best_re_d;
      best_qb_q       <= best_qb_d;
      best_qe_q       <= best_qe_d;
      ovf_q           <= ovf_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign total_score_o       = score_q;
  assign ref_extent_o        = ref_q;
  assign query_extent_o      = query_q;
  assign total_length_o      = len_q;
  assign local_score_o       = best_q;
  assign local_ref_begin_o   = best_rb_q;
  assign local_ref_end_o     = best_re_q;
  assign local_query_begin_o = best_qb_q;
  assign local_query_end_o   = best_qe_q;
  assign length_overflow_o   = ovf_q;

  `CASLT_ASSERT(a_best_ge_running, best_q >= running_q, "running score above best")
  `CASLT_ASSERT(a_seg_order, (best_re_q >= best_rb_q) && (best_qe_q >= best_qb_q),
                "segment end before begin")
  `CASLT_ASSERT_NEXT(a_ovf_sticky, ovf_q && !(advance && in_op_q == caslt_pkg::OP_CLEAR),
                     ovf_q, "overflow flag dropped without clear")
  `CASLT_ASSERT(a_hold_on_stall, in_valid_q && out_valid_q && out_stall_i |-> in_stall_o,
                "input taken while result held")

endmodule
